FILE: rtl/lkvc_pkg.sv
// shared types and constants for the lru key/value cache
package lkvc_pkg;

   localparam int KEY_BITS        = 32;
   localparam int VALUE_PORT_BITS = 64;
   localparam int CSR_BITS        = 7;

   localparam logic [CSR_BITS-1:0] CAP_RESET = 7'd64;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_DECIDE,
      ST_FETCH,
      ST_UPDATE,
      ST_UPD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear;
      logic sample;
      logic is_insert;
   } scan_ctl_type;

endpackage

FILE: rtl/lkvc_select.sv
// scan selector: best key match, least recent entry and first free slot
module lkvc_select #(
   parameter int IDX_BITS  = 6,
   parameter int RANK_BITS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkvc_pkg::scan_ctl_type ctl,
   input  logic                   entry_valid,
   input  logic [RANK_BITS-1:0]   entry_rank,
   input  logic                   key_match,
   input  logic [IDX_BITS-1:0]    entry_idx,
   output logic                   found,
   output logic [IDX_BITS-1:0]    slot,
   output logic [RANK_BITS-1:0]   rank,
   output logic                   free_found,
   output logic [IDX_BITS-1:0]    free_slot
);
   import lkvc_pkg::*;

   logic                 found_ff, found_in;
   logic                 free_found_ff, free_found_in;
   logic [IDX_BITS-1:0]  slot_ff, slot_in;
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic [IDX_BITS-1:0]  free_slot_ff, free_slot_in;
   logic                 take;
   logic                 take_free;

   always_comb begin
      if (ctl.is_insert) begin
         take = entry_valid && (!found_ff || entry_rank > rank_ff);
      end else begin
         take = entry_valid && key_match && (!found_ff || entry_rank < rank_ff);
      end
      take_free = ctl.is_insert && !entry_valid && !free_found_ff;

      found_in      = found_ff;
      slot_in       = slot_ff;
      rank_in       = rank_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      if (ctl.clear) begin
         found_in      = 1'b0;
         free_found_in = 1'b0;
      end else if (ctl.sample) begin
         if (take) begin
            found_in = 1'b1;
            slot_in  = entry_idx;
            rank_in  = entry_rank;
         end
         if (take_free) begin
            free_found_in = 1'b1;
            free_slot_in  = entry_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      rank_ff      <= rank_in;
      free_slot_ff <= free_slot_in;
   end

   assign found      = found_ff;
   assign slot       = slot_ff;
   assign rank       = rank_ff;
   assign free_found = free_found_ff;
   assign free_slot  = free_slot_ff;

endmodule

FILE: rtl/lru_key_value_cache_core.sv
// lru key/value cache core: fsm, entry and recency memories, response register
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_cmd, req_lookup_key, req_value_in
//   rsp      out        rsp_valid/rsp_stall  rsp_hit, rsp_value_out, rsp_evicted
//   csr      in         csr_valid/csr_ready  csr_capacity_in_use
//
// a lookup miss runs the match scan only, a hit or insert also runs the rank update pass
// the recency memory is read once per entry on the match scan, then read and
// written back once per entry on the rank update pass
// after reset a clearing pass over every entry runs with req_stall high
// a new request is taken while the previous response still waits on rsp_stall
// csr writes are taken in every cycle
module lru_key_value_cache_core #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_cmd,
   input  logic [lkvc_pkg::KEY_BITS-1:0]          req_lookup_key,
   input  logic [lkvc_pkg::VALUE_PORT_BITS-1:0]   req_value_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   output logic [lkvc_pkg::VALUE_PORT_BITS-1:0]   rsp_value_out,
   output logic                                   rsp_evicted,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lkvc_pkg::CSR_BITS-1:0]          csr_capacity_in_use
);
   import lkvc_pkg::*;

   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_BITS  = IDX_BITS;
   localparam int META_BITS  = RANK_BITS + 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int CMP_BITS   = (CNT_BITS > CSR_BITS) ? CNT_BITS : CSR_BITS;
   localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);
   localparam logic [CMP_BITS-1:0] CAP_LIMIT = CMP_BITS'(CAPACITY);

   state_type              state_ff, state_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic                   pv_ff, pv_in;
   logic [IDX_BITS-1:0]    pidx_ff, pidx_in;
   logic                   cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CSR_BITS-1:0]    cap_ff, cap_in;
   logic                   hit_ff, hit_in;
   logic                   evict_ff, evict_in;
   logic [IDX_BITS-1:0]    new_slot_ff, new_slot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [VALUE_PORT_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;

   logic [META_BITS-1:0]   meta_mem [CAPACITY];
   logic [META_BITS-1:0]   meta_q;
   logic [IDX_BITS-1:0]    meta_raddr;
   logic                   meta_we;
   logic [IDX_BITS-1:0]    meta_waddr;
   logic [META_BITS-1:0]   meta_wdata;
   logic [META_BITS-1:0]   upd_meta;

   logic [ENTRY_BITS-1:0]  entry_mem [CAPACITY];
   logic [ENTRY_BITS-1:0]  entry_q;
   logic [IDX_BITS-1:0]    entry_raddr;
   logic                   entry_we;
   logic [IDX_BITS-1:0]    entry_waddr;

   logic                   mv;
   logic [RANK_BITS-1:0]   mr;
   logic                   key_match;
   scan_ctl_type           sel_ctl;
   logic                   sel_found;
   logic [IDX_BITS-1:0]    sel_slot;
   logic [RANK_BITS-1:0]   sel_rank;
   logic                   sel_free_found;
   logic [IDX_BITS-1:0]    sel_free_slot;

   logic [CMP_BITS-1:0]    cap_ext;
   logic [CMP_BITS-1:0]    eff_cap;
   logic                   full;
   logic                   evict_c;
   logic [IDX_BITS-1:0]    new_slot_c;
   logic                   out_free;

   // memories
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_q <= meta_mem[meta_raddr];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= {key_ff, val_ff};
      end
      entry_q <= entry_mem[entry_raddr];
   end

   assign mv        = meta_q[RANK_BITS];
   assign mr        = meta_q[RANK_BITS-1:0];
   assign key_match = (entry_q[ENTRY_BITS-1 -: KEY_BITS] == key_ff);

   lkvc_select #(
      .IDX_BITS  (IDX_BITS),
      .RANK_BITS (RANK_BITS)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .ctl         (sel_ctl),
      .entry_valid (mv),
      .entry_rank  (mr),
      .key_match   (key_match),
      .entry_idx   (pidx_ff),
      .found       (sel_found),
      .slot        (sel_slot),
      .rank        (sel_rank),
      .free_found  (sel_free_found),
      .free_slot   (sel_free_slot)
   );

   // effective capacity and insert decision
   always_comb begin
      cap_ext = CMP_BITS'(cap_ff);
      if (cap_ext == '0) begin
         eff_cap = CMP_BITS'(1);
      end else if (cap_ext > CAP_LIMIT) begin
         eff_cap = CAP_LIMIT;
      end else begin
         eff_cap = cap_ext;
      end
      full    = (CMP_BITS'(count_ff) >= eff_cap);
      evict_c = full && sel_found;
      if (evict_c && !(sel_free_found && (sel_free_slot < sel_slot))) begin
         new_slot_c = sel_slot;
      end else begin
         new_slot_c = sel_free_slot;
      end
   end

   // rank update for the write-back pass
   always_comb begin
      upd_meta = meta_q;
      if (cmd_ff == CMD_LOOKUP) begin
         if (pidx_ff == sel_slot) begin
            upd_meta = {1'b1, {RANK_BITS{1'b0}}};
         end else if (mv && (mr < sel_rank)) begin
            upd_meta = {1'b1, mr + RANK_BITS'(1)};
         end
      end else begin
         if (pidx_ff == new_slot_ff) begin
            upd_meta = {1'b1, {RANK_BITS{1'b0}}};
         end else if (evict_ff && (pidx_ff == sel_slot)) begin
            upd_meta = '0;
         end else if (mv) begin
            upd_meta = {1'b1, mr + RANK_BITS'(1)};
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      pv_in          = 1'b0;
      pidx_in        = idx_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      count_in       = count_ff;
      hit_in         = hit_ff;
      evict_in       = evict_ff;
      new_slot_in    = new_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      meta_raddr     = idx_ff;
      meta_we        = 1'b0;
      meta_waddr     = pidx_ff;
      meta_wdata     = upd_meta;
      entry_raddr    = idx_ff;
      entry_we       = 1'b0;
      entry_waddr    = new_slot_c;
      sel_ctl.clear     = 1'b0;
      sel_ctl.sample    = 1'b0;
      sel_ctl.is_insert = (cmd_ff == CMD_INSERT);

      case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = idx_ff;
            meta_wdata = '0;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               key_in        = req_lookup_key;
               val_in        = req_value_in[VALUE_BITS-1:0];
               hit_in        = 1'b0;
               evict_in      = 1'b0;
               idx_in        = '0;
               sel_ctl.clear = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pv_in          = 1'b1;
            sel_ctl.sample = pv_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCAN_WAIT;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         ST_SCAN_WAIT: begin
            sel_ctl.sample = pv_ff;
            state_in       = ST_DECIDE;
         end
         ST_DECIDE: begin
            idx_in = '0;
            if (cmd_ff == CMD_LOOKUP) begin
               entry_raddr = sel_slot;
               hit_in      = sel_found;
               state_in    = sel_found ? ST_FETCH : ST_DONE;
            end else begin
               entry_we    = 1'b1;
               evict_in    = evict_c;
               new_slot_in = new_slot_c;
               count_in    = count_ff + CNT_BITS'(1) - CNT_BITS'(evict_c);
               state_in    = ST_UPDATE;
            end
         end
         ST_FETCH: begin
            val_in   = entry_q[VALUE_BITS-1:0];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            pv_in   = 1'b1;
            meta_we = pv_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_UPD_WAIT;
            end else begin
               idx_in = idx_ff + IDX_BITS'(1);
            end
         end
         ST_UPD_WAIT: begin
            meta_we  = pv_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = hit_ff;
               rsp_value_in   = hit_ff ? VALUE_PORT_BITS'(val_ff) : '0;
               rsp_evicted_in = evict_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         pv_ff        <= 1'b0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         hit_ff       <= 1'b0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pv_ff        <= pv_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         hit_ff       <= hit_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff        <= pidx_in;
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      new_slot_ff    <= new_slot_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   assign cap_in    = csr_valid ? csr_capacity_in_use : cap_ff;
   assign csr_ready = 1'b1;

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_evicted   = rsp_evicted_ff;

endmodule
